### rtl/wds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wds_pkg: shared constants and types of the 2D Wilson hopping operator.
// Lattice size, store geometry, operation codes and register indexes.
// ----------------------------------------------------------------------------
package wds_pkg;
	localparam int LAT_X = 64;
	localparam int LAT_T = 64;
	localparam int XW = $clog2(LAT_X);
	localparam int TW = $clog2(LAT_T);
	localparam int DEPTH = 2 * LAT_X * LAT_T;
	localparam int AW = $clog2(DEPTH);
	localparam int WORD_W = 64;

	localparam logic [1:0] OP_LINK = 2'd0;
	localparam logic [1:0] OP_SRC = 2'd1;
	localparam logic [1:0] OP_COMPUTE = 2'd2;
	// Reserved code: accepted and ignored.
	localparam logic [1:0] OP_RSVD = 2'd3;

	localparam logic REG_MASS = 1'b0;
	localparam logic REG_DAGGER = 1'b1;

	localparam logic signed [27:0] MASS_RESET = 28'sd16777216;
	localparam logic signed [31:0] TWO_Q24 = 32'sd33554432;

	typedef logic [AW-1:0] addr_t;
endpackage

### rtl/wds_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wds_ram: generic single-port RAM with registered read.
// One write or one read per cycle; read data is registered and appears in the cycle after the address.
// ----------------------------------------------------------------------------
module wds_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Read first port, registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

### rtl/wilson_dirac_stencil_2d.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wilson_dirac_stencil_2d: Wilson hopping operator on a periodic 2D lattice.
// Source and link stores in single-port RAMs, one shared complex datapath.
// ----------------------------------------------------------------------------
// Usage:
//  - Input stream s_axis: tuser holds the operation (0 link write, 1 source
//    write, 2 compute). Writes give no output.
//  - A compute transaction reads ten source words and four link words, one
//    source and at most one link per cycle, and accumulates five terms in a
//    sequencer. Output valid rises once the ten read steps are done and the
//    pipeline has drained; the next item is taken only after the output
//    handshake, when the block is back in idle.
//  - Output stream m_axis carries both spin results from the accumulator registers.
//    While the receiver stalls the result is held; the next item is taken
//    only after the result has been delivered.
//  - Configuration channel cfg writes mass (index 0) and dagger_mode (1);
//    write it only while the block is idle.
//  - Reset (arst_n low) clears the sequencer and the registers to mass 1.0
//    and dagger_mode 0. The stores are not cleared; read only written sites.
// ----------------------------------------------------------------------------
module wilson_dirac_stencil_2d (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// tdata: site_x[5:0], site_t[11:6], component[12], value_re[44:13],
	// value_im[76:45], zero [79:77]
	input  logic [79:0]  s_axis_tdata,
	// tuser: operation[1:0]
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// tdata: upper_re[31:0], upper_im[63:32], lower_re[95:64], lower_im[127:96]
	output logic [127:0] m_axis_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_index,
	input  logic [27:0]  cfg_data
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN = 2'd1;
	localparam logic [1:0] ST_OUT = 2'd2;

	logic [1:0] state_q;
	logic [3:0] step_q;
	logic signed [27:0] mass_q;
	logic dag_q;
	logic [wds_pkg::XW-1:0] x_q;
	logic [wds_pkg::TW-1:0] t_q;

	// Accumulators for the four output components.
	logic signed [41:0] d0r_q, d0i_q, d1r_q, d1i_q;
	logic signed [31:0] s0r_q, s0i_q;

	logic in_acc, out_acc;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;
	assign cfg_ready = 1'b1;

	logic [wds_pkg::XW-1:0] in_x;
	logic [wds_pkg::TW-1:0] in_t;
	assign in_x = s_axis_tdata[wds_pkg::XW-1:0];
	assign in_t = s_axis_tdata[6 +: wds_pkg::TW];

	// Neighbour coordinates.
	logic [wds_pkg::XW-1:0] xp, xm;
	logic [wds_pkg::TW-1:0] tp, tm;
	assign xp = (x_q == wds_pkg::XW'(wds_pkg::LAT_X - 1)) ? '0 : x_q + 1'b1;
	assign xm = (x_q == '0) ? wds_pkg::XW'(wds_pkg::LAT_X - 1) : x_q - 1'b1;
	assign tp = (t_q == wds_pkg::TW'(wds_pkg::LAT_T - 1)) ? '0 : t_q + 1'b1;
	assign tm = (t_q == '0) ? wds_pkg::TW'(wds_pkg::LAT_T - 1) : t_q - 1'b1;

	function automatic wds_pkg::addr_t mk_addr(input logic [wds_pkg::XW-1:0] x,
			input logic [wds_pkg::TW-1:0] t, input logic c);
		mk_addr = {x, t, c};
	endfunction

	// Read schedule: step k reads source word k (site k/2, spin k%2).
	// Term j = k/2; 0 centre, 1 x+1, 2 x-1, 3 t+1, 4 t-1.
	logic [2:0] rd_term;
	logic [wds_pkg::XW-1:0] rx;
	logic [wds_pkg::TW-1:0] rt;
	assign rd_term = step_q[3:1];
	always_comb begin
		rx = x_q;
		rt = t_q;
		case (rd_term)
			3'd1: rx = xp;
			3'd2: rx = xm;
			3'd3: rt = tp;
			3'd4: rt = tm;
			default: ;
		endcase
	end

	logic [wds_pkg::XW-1:0] lx;
	logic [wds_pkg::TW-1:0] lt;
	logic lc;
	always_comb begin
		lx = x_q;
		lt = t_q;
		lc = 1'b0;
		case (rd_term)
			3'd2: lx = xm;
			3'd3: lc = 1'b1;
			3'd4: begin
				lt = tm;
				lc = 1'b1;
			end
			default: ;
		endcase
	end

	logic in_src_we, in_lnk_we;
	assign in_src_we = in_acc && (s_axis_tuser == wds_pkg::OP_SRC);
	assign in_lnk_we = in_acc && (s_axis_tuser == wds_pkg::OP_LINK);

	wds_pkg::addr_t src_addr, lnk_addr, wr_addr;
	assign wr_addr = mk_addr(in_x, in_t, s_axis_tdata[12]);
	assign src_addr = (state_q == ST_RUN) ? mk_addr(rx, rt, step_q[0]) : wr_addr;
	assign lnk_addr = (state_q == ST_RUN) ? mk_addr(lx, lt, lc) : wr_addr;

	logic [63:0] src_rd, lnk_rd;
	wds_ram #(.WIDTH(wds_pkg::WORD_W), .DEPTH(wds_pkg::DEPTH)) u_src (
		.clk(clk), .we(in_src_we), .addr(src_addr),
		.wdata(s_axis_tdata[76:13]), .rdata(src_rd));
	wds_ram #(.WIDTH(wds_pkg::WORD_W), .DEPTH(wds_pkg::DEPTH)) u_lnk (
		.clk(clk), .we(in_lnk_we), .addr(lnk_addr),
		.wdata(s_axis_tdata[76:13]), .rdata(lnk_rd));

	// Stage 1: data for step_s1 arrives from the RAMs.
	logic valid_s1;
	logic [3:0] step_s1;
	logic [63:0] lnk_s1;

	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		if (v > 34'sd2147483647) sat32 = 32'sh7fffffff;
		else if (v < -34'sd2147483648) sat32 = 32'sh80000000;
		else sat32 = v[31:0];
	endfunction

	function automatic logic signed [31:0] sat_acc(input logic signed [41:0] v);
		if (v > 42'sd2147483647) sat_acc = 32'sh7fffffff;
		else if (v < -42'sd2147483648) sat_acc = 32'sh80000000;
		else sat_acc = v[31:0];
	endfunction

	// Projection on arrival of the spin 1 word.
	logic signed [31:0] a1r, a1i, a1r_f, a1i_f;
	logic signed [31:0] hr, hi;
	logic [2:0] term_s1;
	assign term_s1 = step_s1[3:1];
	assign a1r = src_rd[31:0];
	assign a1i = src_rd[63:32];
	assign a1r_f = a1r;
	assign a1i_f = a1i;
	always_comb begin
		logic signed [33:0] pr, pi;
		logic sg;
		sg = dag_q;
		pr = 34'(s0r_q);
		pi = 34'(s0i_q);
		case (term_s1)
			3'd1: begin
				pr = sg ? pr - 34'(a1r_f) : pr + 34'(a1r_f);
				pi = sg ? pi - 34'(a1i_f) : pi + 34'(a1i_f);
			end
			3'd2: begin
				pr = sg ? pr + 34'(a1r_f) : pr - 34'(a1r_f);
				pi = sg ? pi + 34'(a1i_f) : pi - 34'(a1i_f);
			end
			3'd3: begin
				pr = sg ? pr + 34'(a1i_f) : pr - 34'(a1i_f);
				pi = sg ? pi - 34'(a1r_f) : pi + 34'(a1r_f);
			end
			default: begin
				pr = sg ? pr - 34'(a1i_f) : pr + 34'(a1i_f);
				pi = sg ? pi + 34'(a1r_f) : pi - 34'(a1r_f);
			end
		endcase
		hr = sat32(pr);
		hi = sat32(pi);
	end

	// Stage 2: four products.
	logic valid_s2, cen_s2;
	logic [2:0] term_s2;
	logic signed [63:0] p_rr_s2, p_ii_s2, p_ri_s2, p_ir_s2;
	logic signed [32:0] cmass;
	assign cmass = -33'(wds_pkg::TWO_Q24) - 33'(mass_q);

	always_ff @(posedge clk) begin
		logic signed [31:0] ur, ui;
		ur = lnk_s1[31:0];
		ui = lnk_s1[63:32];
		if (term_s1 == 3'd0) begin
			// Mass term for one spin word: re in rr, im in ri.
			p_rr_s2 <= 64'(cmass * $signed(src_rd[31:0]));
			p_ri_s2 <= 64'(cmass * $signed(src_rd[63:32]));
			p_ii_s2 <= '0;
			p_ir_s2 <= '0;
		end else begin
			p_rr_s2 <= hr * ur;
			p_ii_s2 <= hi * ui;
			p_ri_s2 <= hr * ui;
			p_ir_s2 <= hi * ur;
		end
		term_s2 <= term_s1;
		cen_s2 <= step_s1[0];
	end

	// Stage 3: round and accumulate.
	function automatic logic signed [41:0] rnd_half(input logic signed [65:0] v);
		logic signed [65:0] s;
		s = (v >>> 1) + 66'sd8388608;
		rnd_half = 42'(s >>> 24);
	endfunction
	function automatic logic signed [41:0] rnd(input logic signed [63:0] v);
		logic signed [64:0] s;
		s = 65'(v) + 65'sd8388608;
		rnd = 42'(s >>> 24);
	endfunction

	logic conj;
	logic signed [65:0] qr_full, qi_full;
	logic signed [41:0] qr, qi;
	assign conj = (term_s2 == 3'd2) || (term_s2 == 3'd4);
	assign qr_full = conj ? 66'(p_rr_s2) + 66'(p_ii_s2) : 66'(p_rr_s2) - 66'(p_ii_s2);
	assign qi_full = conj ? 66'(p_ir_s2) - 66'(p_ri_s2) : 66'(p_ri_s2) + 66'(p_ir_s2);
	assign qr = rnd_half(qr_full);
	assign qi = rnd_half(qi_full);

	// Control sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			mass_q <= wds_pkg::MASS_RESET;
			dag_q <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == wds_pkg::REG_MASS) mass_q <= $signed(cfg_data);
				else dag_q <= cfg_data[0];
			end
			valid_s1 <= (state_q == ST_RUN);
			valid_s2 <= valid_s1;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && s_axis_tuser == wds_pkg::OP_COMPUTE) begin
						state_q <= ST_RUN;
						step_q <= '0;
					end
				end
				ST_RUN: begin
					step_q <= step_q + 1'b1;
					if (step_q == 4'd9) state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!valid_s1 && !valid_s2 && !m_axis_tvalid) begin
						m_axis_tvalid <= 1'b1;
					end
					if (out_acc) begin
						m_axis_tvalid <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_q <= in_x;
			t_q <= in_t;
		end
		step_s1 <= step_q;
		lnk_s1 <= lnk_rd;
		if (valid_s1 && !step_s1[0]) begin
			s0r_q <= src_rd[31:0];
			s0i_q <= src_rd[63:32];
		end
		if (in_acc) begin
			d0r_q <= '0;
			d0i_q <= '0;
			d1r_q <= '0;
			d1i_q <= '0;
		end else if (valid_s2) begin
			if (term_s2 == 3'd0) begin
				if (!cen_s2) begin
					d0r_q <= d0r_q + rnd(p_rr_s2);
					d0i_q <= d0i_q + rnd(p_ri_s2);
				end else begin
					d1r_q <= d1r_q + rnd(p_rr_s2);
					d1i_q <= d1i_q + rnd(p_ri_s2);
				end
			end else if (cen_s2) begin
				d0r_q <= d0r_q + qr;
				d0i_q <= d0i_q + qi;
				case (term_s2)
					3'd1: begin
						d1r_q <= dag_q ? d1r_q - qr : d1r_q + qr;
						d1i_q <= dag_q ? d1i_q - qi : d1i_q + qi;
					end
					3'd2: begin
						d1r_q <= dag_q ? d1r_q + qr : d1r_q - qr;
						d1i_q <= dag_q ? d1i_q + qi : d1i_q - qi;
					end
					3'd3: begin
						d1r_q <= dag_q ? d1r_q - qi : d1r_q + qi;
						d1i_q <= dag_q ? d1i_q + qr : d1i_q - qr;
					end
					default: begin
						d1r_q <= dag_q ? d1r_q + qi : d1r_q - qi;
						d1i_q <= dag_q ? d1i_q - qr : d1i_q + qr;
					end
				endcase
			end
		end
	end

	assign m_axis_tdata = {sat_acc(d1i_q), sat_acc(d1r_q), sat_acc(d0i_q), sat_acc(d0r_q)};
endmodule

### rtl/wds_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wds_checker: port-level checks of the Wilson stencil block.
// Watches handshakes on the input and output channels.
// ----------------------------------------------------------------------------
module wds_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [127:0] m_axis_tdata
);
	// A pending result holds its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// No input is taken while a result waits.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("input ready while result pending");

	// After a delivered result the block takes input again.
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid && s_axis_tready)
		else $error("block not free after result");

	// A result never appears right after accepting an item.
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
		else $error("result too early");
endmodule

bind wilson_dirac_stencil_2d wds_checker u_wds_checker (
	.clk(clk), .arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata));
